/* hdl/bres_pkg.sv */
// shared types, widths and codes for the bresenham line generator
`timescale 1ns / 1ps
`default_nettype none

package bres_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int REG_BITS   = 13;
  localparam int ADDR_BITS  = 24;
  localparam int COLOR_BITS = 32;
  localparam int PADDR_BITS = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [REG_BITS-1:0] VIS_WIDTH_RESET  = 13'd640;
  localparam logic [REG_BITS-1:0] VIS_HEIGHT_RESET = 13'd480;
  localparam logic [REG_BITS-1:0] ROW_PITCH_RESET  = 13'd640;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_VIS_WIDTH  = 2'd0,
    REG_VIS_HEIGHT = 2'd1,
    REG_ROW_PITCH  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [REG_BITS-1:0] vis_width;
    logic [REG_BITS-1:0] vis_height;
    logic [REG_BITS-1:0] row_pitch;
  } cfg_t;

  typedef struct packed {
    logic                         active;
    logic                         steep;
    logic signed [COORD_BITS-1:0] major_pos;
    logic signed [COORD_BITS-1:0] major_stop;
    logic signed [COORD_BITS-1:0] minor_pos;
    logic signed [ERR_BITS-1:0]   error_term;
    logic [DELTA_BITS-1:0]        delta_major;
    logic [DELTA_BITS-1:0]        delta_minor;
    logic                         step_down;
    logic [COLOR_BITS-1:0]        color;
  } line_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [ADDR_BITS-1:0]         address;
    logic [COLOR_BITS-1:0]        color;
    logic                         write_enable;
    logic                         last;
  } pixel_t;

endpackage

`default_nettype wire

/* hdl/bres_cfg.sv */
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module bres_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bres_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [bres_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [bres_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output bres_pkg::cfg_t                      cfg
);

  bres_pkg::reg_index_t index;
  logic                 wr;

  assign index  = bres_pkg::reg_index_t'(paddr[bres_pkg::PADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vis_width  <= bres_pkg::VIS_WIDTH_RESET;
      cfg.vis_height <= bres_pkg::VIS_HEIGHT_RESET;
      cfg.row_pitch  <= bres_pkg::ROW_PITCH_RESET;
    end else if (wr) begin
      case (index)
        bres_pkg::REG_VIS_WIDTH:  cfg.vis_width  <= pwdata[bres_pkg::REG_BITS-1:0];
        bres_pkg::REG_VIS_HEIGHT: cfg.vis_height <= pwdata[bres_pkg::REG_BITS-1:0];
        bres_pkg::REG_ROW_PITCH:  cfg.row_pitch  <= pwdata[bres_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      bres_pkg::REG_VIS_WIDTH:  prdata = bres_pkg::DATA_BITS'(cfg.vis_width);
      bres_pkg::REG_VIS_HEIGHT: prdata = bres_pkg::DATA_BITS'(cfg.vis_height);
      bres_pkg::REG_ROW_PITCH:  prdata = bres_pkg::DATA_BITS'(cfg.row_pitch);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/bres_load.sv */
// line setup: axis choice, endpoint ordering, deltas and initial error term
`timescale 1ns / 1ps
`default_nettype none

module bres_load (
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] x_start,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] y_start,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] x_end,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] y_end,
  input  wire logic        [bres_pkg::COLOR_BITS-1:0] draw_color,
  output bres_pkg::line_t                             line
);

  logic signed [bres_pkg::DELTA_BITS-1:0] dx;
  logic signed [bres_pkg::DELTA_BITS-1:0] dy;
  logic        [bres_pkg::DELTA_BITS-1:0] adx;
  logic        [bres_pkg::DELTA_BITS-1:0] ady;
  logic signed [bres_pkg::DELTA_BITS-1:0] dmin;
  logic signed [bres_pkg::DELTA_BITS-1:0] dmaj;
  logic        [bres_pkg::DELTA_BITS-1:0] admin;
  logic signed [bres_pkg::COORD_BITS-1:0] a0;
  logic signed [bres_pkg::COORD_BITS-1:0] b0;
  logic signed [bres_pkg::COORD_BITS-1:0] a1;
  logic signed [bres_pkg::COORD_BITS-1:0] b1;
  logic                                   steep;

  assign dx  = bres_pkg::DELTA_BITS'(x_end) - bres_pkg::DELTA_BITS'(x_start);
  assign dy  = bres_pkg::DELTA_BITS'(y_end) - bres_pkg::DELTA_BITS'(y_start);
  assign adx = dx[bres_pkg::DELTA_BITS-1] ? -dx : dx;
  assign ady = dy[bres_pkg::DELTA_BITS-1] ? -dy : dy;
  assign steep = !(ady < adx);

  always_comb begin
    if (!steep) begin
      if (x_start > x_end) begin
        a0 = x_end;   b0 = y_end;   a1 = x_start; b1 = y_start;
      end else begin
        a0 = x_start; b0 = y_start; a1 = x_end;   b1 = y_end;
      end
    end else begin
      if (y_start > y_end) begin
        a0 = y_end;   b0 = x_end;   a1 = y_start; b1 = x_start;
      end else begin
        a0 = y_start; b0 = x_start; a1 = y_end;   b1 = x_end;
      end
    end
  end

  assign dmin  = bres_pkg::DELTA_BITS'(b1) - bres_pkg::DELTA_BITS'(b0);
  assign dmaj  = bres_pkg::DELTA_BITS'(a1) - bres_pkg::DELTA_BITS'(a0);
  assign admin = dmin[bres_pkg::DELTA_BITS-1] ? -dmin : dmin;

  always_comb begin
    line.active      = a0 < a1;
    line.steep       = steep;
    line.major_pos   = a0;
    line.major_stop  = a1;
    line.minor_pos   = b0;
    line.delta_major = dmaj;
    line.delta_minor = admin;
    line.step_down   = dmin[bres_pkg::DELTA_BITS-1];
    line.color       = draw_color;
    // 2*dminor - dmajor
    line.error_term  = (bres_pkg::ERR_BITS'(admin) << 1) - bres_pkg::ERR_BITS'(dmaj);
  end

endmodule

`default_nettype wire

/* hdl/bres_pixel.sv */
// one pixel step: coordinates, clipping, address and the error-term update
`timescale 1ns / 1ps
`default_nettype none

module bres_pixel (
  input  wire bres_pkg::line_t line,
  input  wire bres_pkg::cfg_t  cfg,
  output bres_pkg::pixel_t     pixel,
  output bres_pkg::line_t      line_next
);

  logic signed [bres_pkg::COORD_BITS-1:0] px;
  logic signed [bres_pkg::COORD_BITS-1:0] py;
  logic        [bres_pkg::ADDR_BITS-1:0]  px_w;
  logic        [bres_pkg::ADDR_BITS-1:0]  py_w;
  logic        [bres_pkg::ADDR_BITS-1:0]  prod;
  logic signed [bres_pkg::DELTA_BITS-1:0] major_inc;
  logic signed [bres_pkg::DELTA_BITS-1:0] stop_ext;
  logic                                   on_screen;
  logic                                   last;
  logic                                   err_pos;

  assign px   = line.steep ? line.minor_pos : line.major_pos;
  assign py   = line.steep ? line.major_pos : line.minor_pos;
  assign px_w = bres_pkg::ADDR_BITS'($unsigned(px));
  assign py_w = bres_pkg::ADDR_BITS'($unsigned(py));

  assign on_screen = !px[bres_pkg::COORD_BITS-1] && !py[bres_pkg::COORD_BITS-1] &&
                     (px_w < bres_pkg::ADDR_BITS'(cfg.vis_width)) &&
                     (py_w < bres_pkg::ADDR_BITS'(cfg.vis_height));

  // address wraps modulo the address width
  assign prod = py_w * bres_pkg::ADDR_BITS'(cfg.row_pitch);

  assign major_inc = bres_pkg::DELTA_BITS'(line.major_pos) + bres_pkg::DELTA_BITS'(1);
  assign stop_ext  = bres_pkg::DELTA_BITS'(line.major_stop);
  assign last      = major_inc >= stop_ext;
  assign err_pos   = !line.error_term[bres_pkg::ERR_BITS-1] && (line.error_term != '0);

  always_comb begin
    pixel.x            = px;
    pixel.y            = py;
    pixel.address      = on_screen ? (px_w + prod) : '0;
    pixel.color        = line.color;
    pixel.write_enable = on_screen;
    pixel.last         = last;

    line_next           = line;
    line_next.major_pos = line.major_pos + bres_pkg::COORD_BITS'(1);
    line_next.active    = !last;
    if (err_pos) begin
      line_next.minor_pos  = line.step_down ? line.minor_pos - bres_pkg::COORD_BITS'(1)
                                            : line.minor_pos + bres_pkg::COORD_BITS'(1);
      line_next.error_term = line.error_term +
                             ((bres_pkg::ERR_BITS'(line.delta_minor) -
                               bres_pkg::ERR_BITS'(line.delta_major)) << 1);
    end else begin
      line_next.error_term = line.error_term + (bres_pkg::ERR_BITS'(line.delta_minor) << 1);
    end
  end

endmodule

`default_nettype wire

/* hdl/bresenham_line_generator.sv */
// top level of the bresenham line generator: input register, line state, pixel register
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   opcode, x_start, y_start, x_end, y_end,
//                                                  draw_color
//   pixel     out        pixel_valid / pixel_stall pixel_x, pixel_y, pixel_address,
//                                                  pixel_color, write_enable, last_pixel
//   config    in         psel / penable / pready   paddr, pwdata, pwrite, prdata
//
// one item per cycle while the pixel output is not stalled: an item waits in the input
// register, then the setup or step logic updates the line state, and a step item loads
// the pixel register and raises pixel valid.
// a stalled pixel holds the pipe; the input register keeps taking items while it is free.
// synchronous reset clears the handshake state, drops any line and restores the registers.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_generator (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic                                  opcode,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] x_start,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] y_start,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] x_end,
  input  wire logic signed [bres_pkg::COORD_BITS-1:0] y_end,
  input  wire logic        [bres_pkg::COLOR_BITS-1:0] draw_color,
  output logic                                       pixel_valid,
  input  wire logic                                  pixel_stall,
  output logic signed      [bres_pkg::COORD_BITS-1:0] pixel_x,
  output logic signed      [bres_pkg::COORD_BITS-1:0] pixel_y,
  output logic             [bres_pkg::ADDR_BITS-1:0]  pixel_address,
  output logic             [bres_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                                       write_enable,
  output logic                                       last_pixel,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic        [bres_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic        [bres_pkg::DATA_BITS-1:0]  pwdata,
  output logic             [bres_pkg::DATA_BITS-1:0]  prdata,
  output logic                                       pready
);

  bres_pkg::cfg_t   cfg;
  bres_pkg::line_t  line;
  bres_pkg::line_t  line_load;
  bres_pkg::line_t  line_step;
  bres_pkg::pixel_t pixel_new;
  bres_pkg::pixel_t pixel;

  logic                                   s1_valid;
  logic                                   s1_opcode;
  logic signed [bres_pkg::COORD_BITS-1:0] s1_x_start;
  logic signed [bres_pkg::COORD_BITS-1:0] s1_y_start;
  logic signed [bres_pkg::COORD_BITS-1:0] s1_x_end;
  logic signed [bres_pkg::COORD_BITS-1:0] s1_y_end;
  logic        [bres_pkg::COLOR_BITS-1:0] s1_color;
  logic                                   go;
  logic                                   emit;

  bres_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bres_load u_load (
    .x_start    (s1_x_start),
    .y_start    (s1_y_start),
    .x_end      (s1_x_end),
    .y_end      (s1_y_end),
    .draw_color (s1_color),
    .line       (line_load)
  );

  bres_pixel u_pixel (
    .line      (line),
    .cfg       (cfg),
    .pixel     (pixel_new),
    .line_next (line_step)
  );

  assign go         = s1_valid && (!pixel_valid || !pixel_stall);
  assign emit       = go && (s1_opcode == bres_pkg::OP_STEP) && line.active;
  assign item_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_opcode  <= opcode;
      s1_x_start <= x_start;
      s1_y_start <= y_start;
      s1_x_end   <= x_end;
      s1_y_end   <= y_end;
      s1_color   <= draw_color;
    end
  end

  // a step while idle leaves the state alone
  always_ff @(posedge clk) begin
    if (rst) begin
      line.active <= 1'b0;
    end else if (go) begin
      if (s1_opcode == bres_pkg::OP_LOAD) begin
        line <= line_load;
      end else if (line.active) begin
        line <= line_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (emit) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel <= pixel_new;
    end
  end

  assign pixel_x       = pixel.x;
  assign pixel_y       = pixel.y;
  assign pixel_address = pixel.address;
  assign pixel_color   = pixel.color;
  assign write_enable  = pixel.write_enable;
  assign last_pixel    = pixel.last;

`ifndef ASSERT_OFF
  a_active_in_range: assert property (@(posedge clk) disable iff (rst)
    line.active |-> (line.major_pos < line.major_stop))
    else $error("active line has no pixel left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && pixel_new.last) |=> !line.active)
    else $error("line still active after its last pixel");

  a_load_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (go && (s1_opcode == bres_pkg::OP_LOAD)) |=>
      (!pixel_valid || $past(pixel_valid && pixel_stall)))
    else $error("load transfer produced a pixel");

  a_clip_address: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !write_enable) |-> (pixel_address == '0))
    else $error("clipped pixel carries an address");

  a_write_on_screen: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && write_enable) |->
      (!pixel_x[bres_pkg::COORD_BITS-1] && !pixel_y[bres_pkg::COORD_BITS-1]))
    else $error("write enabled for negative coordinate");
`endif

endmodule

`default_nettype wire
